// File: hw/rtl/tour_length_accumulator_core_macros.svh
// Assertion macros used by the tour length accumulator checker.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef TOUR_LENGTH_ACCUMULATOR_CORE_MACROS_SVH
`define TOUR_LENGTH_ACCUMULATOR_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define TLAC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("tlac: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define TLAC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlac: next-cycle check failed");

`endif

// File: hw/rtl/tlac_pkg.sv
// Shared field widths for the tour length accumulator.
// No dependencies; used by the core and its checker.
package tlac_pkg;

  localparam int CITY_W  = 8;
  localparam int COORD_W = 16;
  localparam int SEG_W   = 17;
  localparam int TOUR_W  = 32;
  localparam int TOTAL_W = 48;
  localparam int TNUM_W  = 16;

endpackage

// File: hw/rtl/tour_length_accumulator_core.sv
// Euclidean tour length accumulator. Load beats (kind 0) write a city's Q12.4
// coordinates into an on-chip table. Tour beats (kind 1) bring city indices
// in visiting order; the first city of a tour gives no result. Every further
// city produces one result beat with the segment length (floor of the
// Euclidean distance, Q.4), the running tour length and the grand total, both
// saturating. Such a beat occupies the block, which accepts no new beat until
// it is through, in steps: two table reads, a difference step, two square
// steps, one step per root bit of the bit-serial square root, and an
// accumulate step that waits for a free output register.
// Depends on tlac_pkg.
module tour_length_accumulator_core #(
  parameter int MAX_CITIES = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [tlac_pkg::CITY_W-1:0]  city_index_i,
  input  logic [tlac_pkg::COORD_W-1:0] x_coord_i,
  input  logic [tlac_pkg::COORD_W-1:0] y_coord_i,
  input  logic                        last_city_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tlac_pkg::CITY_W-1:0]  from_city_o,
  output logic [tlac_pkg::CITY_W-1:0]  to_city_o,
  output logic [tlac_pkg::SEG_W-1:0]   segment_length_o,
  output logic [tlac_pkg::TOUR_W-1:0]  tour_length_o,
  output logic [tlac_pkg::TOTAL_W-1:0] total_length_o,
  output logic [tlac_pkg::TNUM_W-1:0]  tour_number_o,
  output logic                        tour_done_o
);
  import tlac_pkg::*;

  // Stored coordinate width: the port carries at most COORD_W bits
  localparam int CW   = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int RW   = CW + 1;          // root bits
  localparam int SW   = 2 * RW;          // radicand bits
  localparam int RMW  = RW + 2;          // remainder bits
  localparam int AW   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int IT_W = $clog2(RW + 1);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_VISIT = 1'b1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD_CUR = 3'd1;
  localparam logic [2:0] ST_DIFF   = 3'd2;
  localparam logic [2:0] ST_SQ_X   = 3'd3;
  localparam logic [2:0] ST_SQ_Y   = 3'd4;
  localparam logic [2:0] ST_ROOT   = 3'd5;
  localparam logic [2:0] ST_ACC    = 3'd6;

  // Coordinate table: {x, y} per city
  logic [2*CW-1:0] mem [MAX_CITIES];
  logic [2*CW-1:0] rd_q;

  logic [2:0]          state_q, state_d;
  logic                first_q, first_d;
  logic [CITY_W-1:0]   prev_city_q, prev_city_d;
  logic [TOUR_W-1:0]   tour_q, tour_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [TNUM_W-1:0]   tnum_q, tnum_d;
  logic                out_valid_q, out_valid_d;

  logic [CITY_W-1:0]   idx_q, idx_d;
  logic                last_q, last_d;
  logic                cur_ok_q, cur_ok_d;
  logic [CW-1:0]       x0_q, x0_d, y0_q, y0_d;
  logic [CW-1:0]       dx_q, dx_d, dy_q, dy_d;
  logic [SW-1:0]       val_q, val_d;
  logic [RMW-1:0]      rem_q, rem_d;
  logic [RW-1:0]       root_q, root_d;
  logic [IT_W-1:0]     iter_q, iter_d;

  logic [CITY_W-1:0]   from_q, to_q;
  logic [SEG_W-1:0]    seg_q;
  logic [TOUR_W-1:0]   otour_q;
  logic [TOTAL_W-1:0]  ototal_q;
  logic [TNUM_W-1:0]   otnum_q;
  logic                odone_q;

  logic                in_fire, acc_fire, mem_we, in_ok, prev_ok;
  logic [31:0]         in_idx_ext, prev_idx_ext, cur_idx_ext;
  logic [AW-1:0]       mem_raddr;
  logic [CW-1:0]       x1, y1;
  logic [RMW+1:0]      shl, trial, diff;
  logic [SEG_W-1:0]    seg;
  logic [TOUR_W:0]     tour_sum;
  logic [TOTAL_W:0]    total_sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign acc_fire   = (state_q == ST_ACC) && (!out_valid_q || out_ready_i);

  // Range checks and table addresses
  assign in_idx_ext   = 32'(city_index_i);
  assign prev_idx_ext = 32'(prev_city_q);
  assign cur_idx_ext  = 32'(idx_q);
  assign in_ok        = in_idx_ext < 32'(MAX_CITIES);
  assign prev_ok      = prev_idx_ext < 32'(MAX_CITIES);
  assign mem_we       = in_fire && (kind_i == KIND_LOAD) && in_ok;
  assign mem_raddr    = (state_q == ST_IDLE) ? prev_idx_ext[AW-1:0] : cur_idx_ext[AW-1:0];

  // Table write on load beats; registered read every cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_idx_ext[AW-1:0]] <= {x_coord_i[CW-1:0], y_coord_i[CW-1:0]};
    end
    rd_q <= mem[mem_raddr];
  end

  // Current city; out of range reads as the origin
  assign x1 = cur_ok_q ? rd_q[2*CW-1:CW] : '0;
  assign y1 = cur_ok_q ? rd_q[CW-1:0] : '0;

  // One restoring square root step
  assign shl   = {rem_q, val_q[SW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = shl - trial;

  // Saturating sums; the root never exceeds SEG_W bits
  assign seg       = SEG_W'(root_q);
  assign tour_sum  = {1'b0, tour_q} + (TOUR_W + 1)'(seg);
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(seg);

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    prev_city_d = prev_city_q;
    tour_d      = tour_q;
    total_d     = total_q;
    tnum_d      = tnum_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    last_d      = last_q;
    cur_ok_d    = cur_ok_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    val_d       = val_q;
    rem_d       = rem_q;
    root_d      = root_q;
    iter_d      = iter_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (kind_i == KIND_VISIT)) begin
          idx_d    = city_index_i;
          last_d   = last_city_i;
          cur_ok_d = in_ok;
          if (first_q) begin
            // First city only opens the segment chain
            prev_city_d = city_index_i;
            first_d     = last_city_i;
            if (last_city_i) begin
              tnum_d = tnum_q + 1'b1;
              tour_d = '0;
            end
          end else begin
            state_d = ST_RD_CUR;
          end
        end
      end
      ST_RD_CUR: begin
        x0_d    = prev_ok ? rd_q[2*CW-1:CW] : '0;
        y0_d    = prev_ok ? rd_q[CW-1:0] : '0;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        dx_d    = (x0_q > x1) ? x0_q - x1 : x1 - x0_q;
        dy_d    = (y0_q > y1) ? y0_q - y1 : y1 - y0_q;
        state_d = ST_SQ_X;
      end
      ST_SQ_X: begin
        val_d   = SW'(dx_q * dx_q);
        state_d = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        val_d   = val_q + SW'(dy_q * dy_q);
        rem_d   = '0;
        root_d  = '0;
        iter_d  = IT_W'(RW);
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (shl >= trial) begin
          rem_d  = diff[RMW-1:0];
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          rem_d  = shl[RMW-1:0];
          root_d = {root_q[RW-2:0], 1'b0};
        end
        val_d  = {val_q[SW-3:0], 2'b00};
        iter_d = iter_q - 1'b1;
        if (iter_q == IT_W'(1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (acc_fire) begin
          tour_d      = tour_sum[TOUR_W] ? '1 : tour_sum[TOUR_W-1:0];
          total_d     = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          out_valid_d = 1'b1;
          prev_city_d = idx_q;
          state_d     = ST_IDLE;
          if (last_q) begin
            tnum_d  = tnum_q + 1'b1;
            tour_d  = '0;
            first_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b1;
      prev_city_q <= '0;
      tour_q      <= '0;
      total_q     <= '0;
      tnum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      prev_city_q <= prev_city_d;
      tour_q      <= tour_d;
      total_q     <= total_d;
      tnum_q      <= tnum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and output register
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    last_q   <= last_d;
    cur_ok_q <= cur_ok_d;
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    val_q    <= val_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    iter_q   <= iter_d;
    if (acc_fire) begin
      from_q   <= prev_city_q;
      to_q     <= idx_q;
      seg_q    <= seg;
      otour_q  <= tour_sum[TOUR_W] ? '1 : tour_sum[TOUR_W-1:0];
      ototal_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      otnum_q  <= tnum_q;
      odone_q  <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign from_city_o      = from_q;
  assign to_city_o        = to_q;
  assign segment_length_o = seg_q;
  assign tour_length_o    = otour_q;
  assign total_length_o   = ototal_q;
  assign tour_number_o    = otnum_q;
  assign tour_done_o      = odone_q;

endmodule

// File: hw/rtl/tlac_checker.sv
// Port-level checker for tour_length_accumulator_core, bound to each instance.
// Depends on tlac_pkg and tour_length_accumulator_core_macros.svh.
`include "tour_length_accumulator_core_macros.svh"

module tlac_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        kind_i,
  input logic [tlac_pkg::CITY_W-1:0]  city_index_i,
  input logic [tlac_pkg::COORD_W-1:0] x_coord_i,
  input logic [tlac_pkg::COORD_W-1:0] y_coord_i,
  input logic                        last_city_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tlac_pkg::CITY_W-1:0]  from_city_o,
  input logic [tlac_pkg::CITY_W-1:0]  to_city_o,
  input logic [tlac_pkg::SEG_W-1:0]   segment_length_o,
  input logic [tlac_pkg::TOUR_W-1:0]  tour_length_o,
  input logic [tlac_pkg::TOTAL_W-1:0] total_length_o,
  input logic [tlac_pkg::TNUM_W-1:0]  tour_number_o,
  input logic                        tour_done_o
);
  import tlac_pkg::*;

  logic unused_in;
  assign unused_in = ^{in_valid_i, in_ready_o, kind_i, city_index_i, x_coord_i,
                       y_coord_i, last_city_i, from_city_o, to_city_o,
                       tour_number_o, tour_done_o};

  // A reported tour length always contains its own segment
  `TLAC_ASSERT_ALWAYS(a_tour_ge_seg, !out_valid_o || (32'(segment_length_o) <= tour_length_o))

  // The grand total never falls below the running tour length
  `TLAC_ASSERT_ALWAYS(a_total_ge_tour, !out_valid_o || (48'(tour_length_o) <= total_length_o))

  // A stalled result beat holds its measured values
  `TLAC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(segment_length_o) && $stable(total_length_o))

endmodule

bind tour_length_accumulator_core tlac_checker u_tlac_checker (.*);
